// ----- sv/tte_pkg.sv -----
`timescale 1ns / 1ps

package tte_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CELL_W = 16;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] SPACE_CODE   = 8'd32;
  localparam logic [7:0] RESET_ATTR   = 8'h07;

  localparam logic [2:0] OP_PUT    = 3'd0;
  localparam logic [2:0] OP_WRITE  = 3'd1;
  localparam logic [2:0] OP_CURSOR = 3'd2;
  localparam logic [2:0] OP_ATTR   = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;
  localparam logic [2:0] OP_READ   = 3'd5;

  typedef struct packed {
    logic [2:0]       opcode;
    logic [7:0]       char_code;
    logic [7:0]       attribute;
    logic [ROW_W-1:0] row_pos;
    logic [COL_W-1:0] col_pos;
  } req_t;

  typedef struct packed {
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic [CELL_W-1:0] cell_value;
    logic              scrolled;
  } rsp_t;

endpackage

// ----- sv/tte_ram.sv -----
`timescale 1ns / 1ps

module tte_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/text_terminal_engine_unit.sv -----
`timescale 1ns / 1ps

// Cursor, attribute, write and plain put requests give their result in the cycle after start.
// Read cell: the store read is registered, then the ST_READ state registers the result.
// Newline or row wrap that scrolls, and clear, are paced by the single store write port
// walking every cell. busy stays high meanwhile.
// Reset: synchronous; busy is high while the store fills with 0x0720.
// Results are strobed for one cycle on out_valid; the receiver cannot stall.
module text_terminal_engine_unit #(
  parameter int COLUMNS = tte_pkg::COLUMNS_DEF,
  parameter int ROWS    = tte_pkg::ROWS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  tte_pkg::req_t in_data,
  output logic          out_valid,
  output tte_pkg::rsp_t out_data
);

  localparam int CELLS  = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int ROW_W  = tte_pkg::ROW_W;
  localparam int COL_W  = tte_pkg::COL_W;
  localparam int CELL_W = tte_pkg::CELL_W;

  localparam logic [ADDR_W-1:0] LAST_COPY  = ADDR_W'(CELLS - COLUMNS - 1);
  localparam logic [ADDR_W-1:0] FIRST_FILL = ADDR_W'(CELLS - COLUMNS);
  localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] COLS_A     = ADDR_W'(COLUMNS);
  localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0]  LAST_COL   = COL_W'(COLUMNS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_FILL
  } state_t;

  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   idx_r, idx_nxt;
  logic                cp_vld_r, cp_vld_nxt;
  logic [ADDR_W-1:0]   cp_addr_r, cp_addr_nxt;
  logic [CELL_W-1:0]   fill_val_r, fill_val_nxt;
  logic                report_r, report_nxt;
  logic                scr_r, scr_nxt;
  logic                rd_ok_r, rd_ok_nxt;
  logic [ROW_W-1:0]    row_now_r, row_now_nxt;
  logic [COL_W-1:0]    col_now_r, col_now_nxt;
  logic [7:0]          attr_now_r, attr_now_nxt;
  logic                out_valid_r, out_valid_nxt;
  tte_pkg::rsp_t       out_data_r, out_data_nxt;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [CELL_W-1:0]   ram_wdata;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [CELL_W-1:0]   ram_rdata;

  logic                accept;
  logic [ADDR_W-1:0]   cur_addr;
  logic [ADDR_W-1:0]   tgt_addr;
  logic                tgt_ok;
  logic [COL_W:0]      col_inc;
  logic [ROW_W:0]      row_inc;
  logic                row_step;
  logic [CELL_W-1:0]   blank;

  assign accept   = start && (state_r == ST_IDLE);
  assign busy     = (state_r != ST_IDLE);
  assign cur_addr = ADDR_W'(ADDR_W'(row_now_r) * COLS_A + ADDR_W'(col_now_r));
  assign tgt_addr = ADDR_W'(ADDR_W'(in_data.row_pos) * COLS_A + ADDR_W'(in_data.col_pos));
  assign tgt_ok   = ({1'b0, in_data.row_pos} < (ROW_W + 1)'(ROWS)) &&
                    ({1'b0, in_data.col_pos} < (COL_W + 1)'(COLUMNS));
  assign col_inc  = {1'b0, col_now_r} + (COL_W + 1)'(1);
  assign row_inc  = {1'b0, row_now_r} + (ROW_W + 1)'(1);
  assign blank    = {attr_now_r, tte_pkg::SPACE_CODE};

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    cp_vld_nxt    = 1'b0;
    cp_addr_nxt   = cp_addr_r;
    fill_val_nxt  = fill_val_r;
    report_nxt    = report_r;
    scr_nxt       = scr_r;
    rd_ok_nxt     = rd_ok_r;
    row_now_nxt   = row_now_r;
    col_now_nxt   = col_now_r;
    attr_now_nxt  = attr_now_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    ram_we        = cp_vld_r;
    ram_waddr     = cp_addr_r;
    ram_wdata     = ram_rdata;
    ram_raddr     = ADDR_W'(idx_r + COLS_A);
    row_step      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_data.opcode)
            tte_pkg::OP_PUT: begin
              if (in_data.char_code == tte_pkg::NEWLINE_CODE) begin
                row_step = 1'b1;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = cur_addr;
                ram_wdata = {attr_now_r, in_data.char_code};
                if (col_inc >= (COL_W + 1)'(COLUMNS)) begin
                  row_step = 1'b1;
                end else begin
                  col_now_nxt = col_inc[COL_W-1:0];
                end
              end
            end
            tte_pkg::OP_WRITE: begin
              ram_we    = tgt_ok;
              ram_waddr = tgt_addr;
              ram_wdata = {in_data.attribute, in_data.char_code};
            end
            tte_pkg::OP_CURSOR: begin
              row_now_nxt = ({1'b0, in_data.row_pos} < (ROW_W + 1)'(ROWS)) ?
                            in_data.row_pos : LAST_ROW;
              col_now_nxt = ({1'b0, in_data.col_pos} < (COL_W + 1)'(COLUMNS)) ?
                            in_data.col_pos : LAST_COL;
            end
            tte_pkg::OP_ATTR: begin
              attr_now_nxt = in_data.attribute;
            end
            tte_pkg::OP_CLEAR: begin
              state_nxt    = ST_FILL;
              idx_nxt      = '0;
              fill_val_nxt = blank;
              report_nxt   = 1'b1;
              scr_nxt      = 1'b0;
              row_now_nxt  = '0;
              col_now_nxt  = '0;
            end
            tte_pkg::OP_READ: begin
              ram_raddr = tgt_addr;
              rd_ok_nxt = tgt_ok;
              state_nxt = ST_READ;
            end
            default: begin
            end
          endcase

          if (row_step) begin
            col_now_nxt = '0;
            if (row_inc >= (ROW_W + 1)'(ROWS)) begin
              row_now_nxt  = LAST_ROW;
              state_nxt    = ST_SCROLL;
              idx_nxt      = '0;
              fill_val_nxt = blank;
              report_nxt   = 1'b1;
              scr_nxt      = 1'b1;
            end else begin
              row_now_nxt = row_inc[ROW_W-1:0];
            end
          end

          if (state_nxt == ST_IDLE) begin
            out_valid_nxt           = 1'b1;
            out_data_nxt.cursor_row = row_now_nxt;
            out_data_nxt.cursor_col = col_now_nxt;
            out_data_nxt.cell_value = '0;
            out_data_nxt.scrolled   = 1'b0;
          end
        end
      end
      ST_READ: begin
        state_nxt               = ST_IDLE;
        out_valid_nxt           = 1'b1;
        out_data_nxt.cursor_row = row_now_r;
        out_data_nxt.cursor_col = col_now_r;
        out_data_nxt.cell_value = rd_ok_r ? ram_rdata : '0;
        out_data_nxt.scrolled   = 1'b0;
      end
      ST_SCROLL: begin
        ram_raddr   = ADDR_W'(idx_r + COLS_A);
        cp_vld_nxt  = 1'b1;
        cp_addr_nxt = idx_r;
        if (idx_r == LAST_COPY) begin
          idx_nxt   = FIRST_FILL;
          state_nxt = ST_FILL;
        end else begin
          idx_nxt = idx_r + ADDR_W'(1);
        end
      end
      ST_FILL: begin
        if (!cp_vld_r) begin
          ram_we    = 1'b1;
          ram_waddr = idx_r;
          ram_wdata = fill_val_r;
          if (idx_r == LAST_CELL) begin
            state_nxt               = ST_IDLE;
            out_valid_nxt           = report_r;
            out_data_nxt.cursor_row = row_now_r;
            out_data_nxt.cursor_col = col_now_r;
            out_data_nxt.cell_value = '0;
            out_data_nxt.scrolled   = scr_r;
          end else begin
            idx_nxt = idx_r + ADDR_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      idx_r       <= '0;
      cp_vld_r    <= 1'b0;
      fill_val_r  <= {tte_pkg::RESET_ATTR, tte_pkg::SPACE_CODE};
      report_r    <= 1'b0;
      scr_r       <= 1'b0;
      row_now_r   <= '0;
      col_now_r   <= '0;
      attr_now_r  <= tte_pkg::RESET_ATTR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      cp_vld_r    <= cp_vld_nxt;
      fill_val_r  <= fill_val_nxt;
      report_r    <= report_nxt;
      scr_r       <= scr_nxt;
      row_now_r   <= row_now_nxt;
      col_now_r   <= col_now_nxt;
      attr_now_r  <= attr_now_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cp_addr_r  <= cp_addr_nxt;
    rd_ok_r    <= rd_ok_nxt;
    out_data_r <= out_data_nxt;
  end

  tte_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_out_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == ST_IDLE))
    else $error("result strobed while engine busy");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, row_now_r} < (ROW_W + 1)'(ROWS)) && ({1'b0, col_now_r} < (COL_W + 1)'(COLUMNS)))
    else $error("cursor out of range");

  a_copy_from_scroll: assert property (@(posedge clk) disable iff (!rst_n)
    cp_vld_r |-> ($past(state_r) == ST_SCROLL))
    else $error("copy write outside scroll pass");

  a_read_path: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_data.opcode == tte_pkg::OP_READ)) |=> (state_r == ST_READ))
    else $error("read request did not enter read state");

  a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.scrolled) |->
      ((out_data_r.cursor_row == LAST_ROW) && (out_data_r.cursor_col == '0)))
    else $error("scrolled result with cursor off last row start");
`endif

endmodule

// ----- test/text_terminal_engine_unit_tb.sv -----
`timescale 1ns / 1ps

module text_terminal_engine_unit_tb;
  import tte_pkg::*;

  localparam int COLS  = COLUMNS_DEF;
  localparam int ROWS  = ROWS_DEF;
  localparam int CELLS = COLS * ROWS;
  localparam logic [ROW_W-1:0] LAST_ROW = 5'(ROWS - 1);
  localparam logic [COL_W-1:0] LAST_COL = 7'(COLS - 1);
  localparam int RANDOM_ITEMS = 1950;
  localparam int DRAIN_CYCLES = CELLS + 100;

  class terminal_scoreboard;
    logic [CELL_W-1:0] screen_cells [0:CELLS-1];
    logic [ROW_W-1:0]  row_q;
    logic [COL_W-1:0]  col_q;
    logic [7:0]        attr_q;
    rsp_t              predicted_results [$];
    int                errors;

    function new();
      for (int i = 0; i < CELLS; i++) screen_cells[i] = {RESET_ATTR, SPACE_CODE};
      row_q  = '0;
      col_q  = '0;
      attr_q = RESET_ATTR;
      errors = 0;
    endfunction

    // advance the cursor one row; scroll at the bottom
    function logic next_row();
      col_q = '0;
      row_q = row_q + 1'b1;
      if (row_q >= ROWS) begin
        for (int i = 0; i < CELLS - COLS; i++) screen_cells[i] = screen_cells[i + COLS];
        for (int i = CELLS - COLS; i < CELLS; i++) screen_cells[i] = {attr_q, SPACE_CODE};
        row_q = LAST_ROW;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_request(req_t rq);
      rsp_t ex;
      ex = '0;
      case (rq.opcode)
        OP_PUT: begin
          if (rq.char_code == NEWLINE_CODE) begin
            ex.scrolled = next_row();
          end else begin
            screen_cells[int'(row_q) * COLS + int'(col_q)] = {attr_q, rq.char_code};
            col_q = col_q + 1'b1;
            if (col_q >= COLS) ex.scrolled = next_row();
          end
        end
        OP_WRITE: begin
          if (rq.row_pos < ROWS && rq.col_pos < COLS)
            screen_cells[int'(rq.row_pos) * COLS + int'(rq.col_pos)] =
              {rq.attribute, rq.char_code};
        end
        OP_CURSOR: begin
          row_q = (rq.row_pos < ROWS) ? rq.row_pos : LAST_ROW;
          col_q = (rq.col_pos < COLS) ? rq.col_pos : LAST_COL;
        end
        OP_ATTR: attr_q = rq.attribute;
        OP_CLEAR: begin
          for (int i = 0; i < CELLS; i++) screen_cells[i] = {attr_q, SPACE_CODE};
          row_q = '0;
          col_q = '0;
        end
        OP_READ: begin
          if (rq.row_pos < ROWS && rq.col_pos < COLS)
            ex.cell_value = screen_cells[int'(rq.row_pos) * COLS + int'(rq.col_pos)];
        end
        default: ;
      endcase
      ex.cursor_row = row_q;
      ex.cursor_col = col_q;
      predicted_results.push_back(ex);
    endfunction

    function void check_result(rsp_t got);
      rsp_t ex;
      if (predicted_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      ex = predicted_results.pop_front();
      if (got.cursor_row !== ex.cursor_row) begin
        $display("%0t: cursor_row expected %0d actual %0d", $time, ex.cursor_row, got.cursor_row);
        errors++;
      end
      if (got.cursor_col !== ex.cursor_col) begin
        $display("%0t: cursor_col expected %0d actual %0d", $time, ex.cursor_col, got.cursor_col);
        errors++;
      end
      if (got.cell_value !== ex.cell_value) begin
        $display("%0t: cell_value expected %h actual %h", $time, ex.cell_value, got.cell_value);
        errors++;
      end
      if (got.scrolled !== ex.scrolled) begin
        $display("%0t: scrolled expected %b actual %b", $time, ex.scrolled, got.scrolled);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  req_t in_data;
  logic out_valid;
  rsp_t out_data;

  terminal_scoreboard sb = new();
  int items_sent;

  text_terminal_engine_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #240_000_000;
    $display("TEST FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && start && !busy) sb.note_request(in_data);
    if (rst_n && out_valid) sb.check_result(out_data);
  end

  function automatic req_t make_request(logic [2:0] op, logic [7:0] ch, logic [7:0] at,
                                        logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
    req_t rq;
    rq.opcode    = op;
    rq.char_code = ch;
    rq.attribute = at;
    rq.row_pos   = r;
    rq.col_pos   = c;
    return rq;
  endfunction

  function automatic req_t random_request();
    req_t        rq;
    logic [31:0] rnd;
    int          pick;
    rnd          = $urandom;
    pick         = $urandom_range(99);
    rq.char_code = rnd[7:0];
    rq.attribute = rnd[15:8];
    rq.row_pos   = rnd[20:16];
    rq.col_pos   = rnd[27:21];
    if ($urandom_range(99) < 75) begin
      rq.row_pos = 5'($urandom_range(ROWS - 1));
      rq.col_pos = 7'($urandom_range(COLS - 1));
    end
    if (pick < 45) begin
      rq.opcode = OP_PUT;
      if ($urandom_range(99) < 4) rq.char_code = NEWLINE_CODE;
    end else if (pick < 55) begin
      rq.opcode = OP_WRITE;
    end else if (pick < 65) begin
      rq.opcode = OP_CURSOR;
    end else if (pick < 72) begin
      rq.opcode = OP_ATTR;
    end else if (pick < 73) begin
      rq.opcode = OP_CLEAR;
    end else if (pick < 94) begin
      rq.opcode = OP_READ;
    end else begin
      rq.opcode = 3'($urandom_range(6, 7));
    end
    return rq;
  endfunction

  task automatic send_request(input req_t rq, input bit allow_idle);
    int gap;
    gap = 0;
    while (allow_idle && $urandom_range(99) < 26) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= rq;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  // park the cursor near the bottom right, type up to or across the wrap, read back
  task automatic scroll_burst(input bit allow_idle);
    int n;
    n = $urandom_range(2, 6);
    send_request(make_request(OP_CURSOR, 8'h00, 8'h00, 5'($urandom_range(ROWS - 2, ROWS - 1)),
                              7'($urandom_range(COLS - 4, COLS - 1))), allow_idle);
    for (int i = 0; i < n; i++) begin
      send_request(make_request(OP_PUT, 8'($urandom_range(32, 255)), 8'h00, 5'd0, 7'd0),
                   allow_idle);
    end
    for (int i = 0; i < 2; i++) begin
      send_request(make_request(OP_READ, 8'h00, 8'h00, 5'($urandom_range(ROWS - 2, ROWS - 1)),
                                7'($urandom_range(COLS - 4, COLS - 1))), allow_idle);
    end
    send_request(make_request(OP_READ, 8'h00, 8'h00, LAST_ROW, 7'd0), allow_idle);
  endtask

  initial begin
    int wait_cycles;
    rst_n      = 1'b0;
    start      = 1'b0;
    in_data    = '0;
    items_sent = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send_request(make_request(OP_PUT,    8'h41,        8'h00, 5'd0,  7'd0),   1'b0);
    send_request(make_request(OP_PUT,    8'h00,        8'h00, 5'd0,  7'd0),   1'b0);
    send_request(make_request(OP_PUT,    8'hFF,        8'h00, 5'd0,  7'd0),   1'b0);
    send_request(make_request(OP_PUT,    NEWLINE_CODE, 8'h00, 5'd0,  7'd0),   1'b0);
    send_request(make_request(OP_ATTR,   8'h00,        8'hFF, 5'd0,  7'd0),   1'b0);
    send_request(make_request(OP_PUT,    8'h7E,        8'h00, 5'd0,  7'd0),   1'b0);
    send_request(make_request(OP_WRITE,  8'hFF,        8'hFF, 5'd0,  7'd0),   1'b0);
    send_request(make_request(OP_WRITE,  8'h5A,        8'hA5, LAST_ROW, LAST_COL), 1'b0);
    send_request(make_request(OP_WRITE,  8'h11,        8'h22, 5'd25, 7'd0),   1'b0);
    send_request(make_request(OP_WRITE,  8'h33,        8'h44, 5'd0,  7'd80),  1'b0);
    send_request(make_request(OP_WRITE,  8'h55,        8'h66, 5'd31, 7'd127), 1'b0);
    send_request(make_request(OP_READ,   8'h00,        8'h00, 5'd0,  7'd0),   1'b0);
    send_request(make_request(OP_READ,   8'h00,        8'h00, LAST_ROW, LAST_COL), 1'b0);
    send_request(make_request(OP_READ,   8'hFF,        8'hFF, 5'd31, 7'd127), 1'b0);
    send_request(make_request(OP_READ,   8'h00,        8'h00, 5'd25, 7'd0),   1'b0);
    send_request(make_request(OP_CURSOR, 8'h00,        8'h00, 5'd31, 7'd127), 1'b0);
    send_request(make_request(OP_PUT,    8'h42,        8'h00, 5'd0,  7'd0),   1'b0);
    send_request(make_request(OP_READ,   8'h00,        8'h00, 5'd23, LAST_COL), 1'b0);
    send_request(make_request(OP_PUT,    NEWLINE_CODE, 8'h00, 5'd0,  7'd0),   1'b0);
    send_request(make_request(OP_CURSOR, 8'h00,        8'h00, 5'd0,  LAST_COL), 1'b0);
    send_request(make_request(OP_PUT,    8'h43,        8'h00, 5'd0,  7'd0),   1'b0);
    send_request(make_request(3'd6,      8'hFF,        8'hFF, 5'd31, 7'd127), 1'b0);
    send_request(make_request(3'd7,      8'h00,        8'h00, 5'd0,  7'd0),   1'b0);
    send_request(make_request(OP_ATTR,   8'h00,        8'h00, 5'd0,  7'd0),   1'b0);
    send_request(make_request(OP_CLEAR,  8'h00,        8'h00, 5'd0,  7'd0),   1'b0);
    send_request(make_request(OP_READ,   8'h00,        8'h00, LAST_ROW, LAST_COL), 1'b0);

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if ($urandom_range(99) < 3)
        scroll_burst(!(items_sent >= 900 && items_sent < 1200));
      else
        send_request(random_request(), !(items_sent >= 900 && items_sent < 1200));
    end
    start <= 1'b0;

    wait_cycles = 0;
    while (sb.predicted_results.size() != 0 && wait_cycles < 4 * DRAIN_CYCLES) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.predicted_results.size() != 0) begin
      $display("%0t: results outstanding, expected 0 actual %0d", $time,
               sb.predicted_results.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/tte_pkg.sv
sv/tte_ram.sv
sv/text_terminal_engine_unit.sv
test/text_terminal_engine_unit_tb.sv
